// ----- rtl/pid_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants of the positional PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    // Operand width of the serial multiplier and its bit counter
    localparam int MUL_W     = 33;
    localparam int MUL_CNT_W = 6;

    // Fixed controller limits, Q16.16
    localparam logic signed [31:0] SETPOINT_MAX = 32'sd2147483647;
    localparam logic signed [31:0] ERROR_LIMIT  = 32'sd2147483647;
    localparam logic signed [31:0] DEAD_ZONE    = 32'sd0;
    localparam logic signed [31:0] PREDICT_GAIN = 32'sd0;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE      = 3'd0,
        CFG_GAIN_P    = 3'd1,
        CFG_GAIN_I    = 3'd2,
        CFG_GAIN_D    = 3'd3,
        CFG_GAIN_FF   = 3'd4,
        CFG_DCOEF     = 3'd5,
        CFG_IBOUND    = 3'd6,
        CFG_OLIMIT    = 3'd7
    } t_cfg_idx;

    // Integral modes
    localparam logic [1:0] IMODE_NORMAL = 2'd0;
    localparam logic [1:0] IMODE_SEP    = 2'd1;
    localparam logic [1:0] IMODE_AWU    = 2'd2;
    localparam logic [1:0] IMODE_TRAP   = 2'd3;

    // Derivative modes
    localparam logic [1:0] DMODE_LPF    = 2'd1;
    localparam logic [1:0] DMODE_SPW    = 2'd2;

    typedef struct packed {
        logic [5:0]         mode;
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i_dt;
        logic signed [31:0] gain_d_dt;
        logic signed [31:0] gain_ff;
        logic signed [31:0] deriv_coef;
        logic [30:0]        integral_bound;
        logic [30:0]        output_limit;
    } t_cfg;

endpackage

// ----- rtl/pid_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pid_cfg_regs
// Configuration register file of the PID controller, write only.
// ----------------------------------------------------------------------------
module pid_cfg_regs import pid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= '0;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i_dt      <= '0;
            r_cfg.gain_d_dt      <= '0;
            r_cfg.gain_ff        <= '0;
            r_cfg.deriv_coef     <= '0;
            r_cfg.integral_bound <= '1;
            r_cfg.output_limit   <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:    r_cfg.mode           <= i_cfg_wdata[5:0];
                CFG_GAIN_P:  r_cfg.gain_p         <= i_cfg_wdata;
                CFG_GAIN_I:  r_cfg.gain_i_dt      <= i_cfg_wdata;
                CFG_GAIN_D:  r_cfg.gain_d_dt      <= i_cfg_wdata;
                CFG_GAIN_FF: r_cfg.gain_ff        <= i_cfg_wdata;
                CFG_DCOEF:   r_cfg.deriv_coef     <= i_cfg_wdata;
                CFG_IBOUND:  r_cfg.integral_bound <= i_cfg_wdata[30:0];
                CFG_OLIMIT:  r_cfg.output_limit   <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/pid_serial_mul.sv -----
// ----------------------------------------------------------------------------
// pid_serial_mul
// Signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pid_serial_mul import pid_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [MUL_W-1:0]    i_a,
    input  logic signed [MUL_W-1:0]    i_b,
    output logic                       o_done,
    output logic signed [2*MUL_W-1:0]  o_prod
);

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_W - 1);

    logic signed [MUL_W:0]   r_a;
    logic signed [MUL_W:0]   r_hi;
    logic [MUL_W-1:0]        r_lo;
    logic [MUL_CNT_W-1:0]    r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic signed [MUL_W:0]   add_op;
    logic signed [MUL_W:0]   sum;

    // The sign bit of the multiplier carries negative weight: subtract on it
    always_comb begin
        add_op = '0;
        if (r_lo[0]) begin
            add_op = (r_cnt == LAST) ? -r_a : r_a;
        end
        sum = r_hi + add_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= {i_a[MUL_W-1], i_a};
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {sum[MUL_W], sum[MUL_W:1]};
            r_lo <= {sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MUL_W-1:0], r_lo};

endmodule

// ----- rtl/pid_position_controller.sv -----
// ----------------------------------------------------------------------------
// pid_position_controller
// Positional PID step in Q16.16 with prediction, dead zone, integral and
// derivative modes, feedforward and output clamp.
// ----------------------------------------------------------------------------
// Sequence: up to seven products run one after another on one bit-serial
// multiplier, with the error, difference and clamp steps between them;
// fewer products run when prediction is off and derivative mode is raw.
// Input: the next sample is taken once the sequencer is back in idle, while
// the previous result may wait.
// Reset: synchronous active low; clears registers to their reset values
// and the integral, last error, filtered derivative and last target to zero.
module pid_position_controller import pid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_setpoint,
    input  logic [31:0] i_measured,
    input  logic [31:0] i_predicted,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_drive,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_FF    = 11'b000_0000_0010,
        ST_SQ    = 11'b000_0000_0100,
        ST_PT    = 11'b000_0000_1000,
        ST_ERR   = 11'b000_0001_0000,
        ST_INT   = 11'b000_0010_0000,
        ST_DIF   = 11'b000_0100_0000,
        ST_DER   = 11'b000_1000_0000,
        ST_P     = 11'b001_0000_0000,
        ST_D     = 11'b010_0000_0000,
        ST_CLAMP = 11'b100_0000_0000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [53:0] x);
        if (x > 54'sd2147483647)       return 32'sh7FFFFFFF;
        else if (x < -54'sd2147483648) return 32'sh80000000;
        else                           return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [53:0] x);
        if (x > 54'sd140737488355327)       return 48'sh7FFFFFFFFFFF;
        else if (x < -54'sd140737488355328) return 48'sh800000000000;
        else                                return x[47:0];
    endfunction

    t_cfg cfg;

    t_state r_state, n_state;
    logic   r_start, n_start;
    logic   r_out_valid;
    logic [31:0] r_drive;

    logic signed [31:0] r_tgt, r_meas, r_p, r_sq, r_err, r_d;
    logic signed [47:0] r_ff, r_pterm;
    logic signed [53:0] r_sum;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_last_err, r_fd, r_last_sp;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic                      mul_done;
    logic signed [2*MUL_W-1:0] prod;
    logic signed [49:0]        sh16;
    logic signed [49:0]        step;

    logic               accept;
    logic               run;
    logic [1:0]         imode, dmode;
    logic signed [31:0] sp_in, tgt_c;
    logic signed [49:0] e_raw;
    logic signed [31:0] err_c;
    logic signed [31:0] d_c;
    logic signed [31:0] ibound, olim;
    logic signed [53:0] acc_sum, acc_new;
    logic signed [53:0] dv;
    logic signed [53:0] out_sum;
    logic signed [31:0] out_c;

    pid_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pid_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    assign run    = cfg.mode[5];
    assign imode  = cfg.mode[1:0];
    assign dmode  = cfg.mode[3:2];
    assign ibound = $signed({1'b0, cfg.integral_bound});
    assign olim   = $signed({1'b0, cfg.output_limit});

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    assign sh16 = prod[65:16];
    assign step = (imode == IMODE_TRAP) ? {prod[65], prod[65:17]} : prod[65:16];

    // Operand select follows the multiply that is being started
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_FF: begin
                mul_a = 33'(cfg.gain_ff);
                mul_b = 33'(r_tgt);
            end
            ST_SQ: begin
                mul_a = 33'(r_p);
                mul_b = r_p[31] ? -33'(r_p) : 33'(r_p);
            end
            ST_PT: begin
                mul_a = 33'(PREDICT_GAIN);
                mul_b = 33'(r_sq);
            end
            ST_INT: begin
                mul_a = 33'(cfg.gain_i_dt);
                mul_b = (imode == IMODE_TRAP) ? 33'(r_err) + 33'(r_last_err) : 33'(r_err);
            end
            ST_DER: begin
                mul_a = 33'(cfg.deriv_coef);
                mul_b = (dmode == DMODE_LPF) ? 33'(r_d) - 33'(r_fd)
                                             : 33'(r_tgt) - 33'(r_last_sp);
            end
            ST_P: begin
                mul_a = 33'(cfg.gain_p);
                mul_b = 33'(r_err);
            end
            ST_D: begin
                mul_a = 33'(cfg.gain_d_dt);
                mul_b = 33'(r_fd);
            end
            default: ;
        endcase
    end

    always_comb begin
        sp_in = $signed(i_setpoint);
        if (sp_in > SETPOINT_MAX)       tgt_c = SETPOINT_MAX;
        else if (sp_in < -SETPOINT_MAX) tgt_c = -SETPOINT_MAX;
        else                            tgt_c = sp_in;

        e_raw = 50'(r_tgt) - 50'(r_meas) - 50'(r_pterm);
        if (e_raw < 50'(DEAD_ZONE) && e_raw > -50'(DEAD_ZONE)) begin
            e_raw = '0;
        end
        if (e_raw > 50'(ERROR_LIMIT))       err_c = ERROR_LIMIT;
        else if (e_raw < -50'(ERROR_LIMIT)) err_c = -ERROR_LIMIT;
        else                                err_c = e_raw[31:0];

        d_c = sat32(54'(r_err) - 54'(r_last_err));

        acc_sum = 54'(r_acc) + 54'(step);
        acc_new = acc_sum;
        if (imode == IMODE_SEP && (54'(r_err) > 54'(ibound) || 54'(r_err) < -54'(ibound))) begin
            acc_new = 54'(r_acc);
        end else if (imode == IMODE_AWU) begin
            if (54'(r_acc) > 54'(ibound))       acc_new = 54'(ibound);
            else if (54'(r_acc) < -54'(ibound)) acc_new = -54'(ibound);
        end

        if (dmode == DMODE_LPF) dv = 54'(r_fd) + 54'(sh16);
        else                    dv = 54'(r_d) - 54'(sh16);

        out_sum = r_sum;
        if (out_sum > 54'(olim))       out_c = olim;
        else if (out_sum < -54'(olim)) out_c = -olim;
        else                           out_c = out_sum[31:0];
    end

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && run) begin
                    n_state = ST_FF;
                    n_start = 1'b1;
                end
            end
            ST_FF: begin
                if (mul_done) begin
                    if (cfg.mode[4] && r_p != 32'sd0) begin
                        n_state = ST_SQ;
                        n_start = 1'b1;
                    end else begin
                        n_state = ST_ERR;
                    end
                end
            end
            ST_SQ: begin
                if (mul_done) begin
                    n_state = ST_PT;
                    n_start = 1'b1;
                end
            end
            ST_PT: begin
                if (mul_done) n_state = ST_ERR;
            end
            ST_ERR: begin
                if (cfg.gain_i_dt == 32'sd0) begin
                    n_state = ST_DIF;
                end else begin
                    n_state = ST_INT;
                    n_start = 1'b1;
                end
            end
            ST_INT: begin
                if (mul_done) n_state = ST_DIF;
            end
            ST_DIF: begin
                n_start = 1'b1;
                n_state = (dmode == DMODE_LPF || dmode == DMODE_SPW) ? ST_DER : ST_P;
            end
            ST_DER: begin
                if (mul_done) begin
                    n_state = ST_P;
                    n_start = 1'b1;
                end
            end
            ST_P: begin
                if (mul_done) begin
                    n_state = ST_D;
                    n_start = 1'b1;
                end
            end
            ST_D: begin
                if (mul_done) n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_last_err  <= '0;
            r_fd        <= '0;
            r_last_sp   <= '0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            if (r_state == ST_ERR && cfg.gain_i_dt == 32'sd0) r_acc <= '0;
            if (r_state == ST_INT && mul_done) r_acc <= sat48(acc_new);
            if (r_state == ST_DIF && dmode != DMODE_LPF && dmode != DMODE_SPW) begin
                r_fd <= d_c;
            end
            if (r_state == ST_DER && mul_done) r_fd <= sat32(dv);
            if (r_state == ST_CLAMP && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_last_err  <= r_err;
                r_last_sp   <= r_tgt;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tgt  <= tgt_c;
            r_meas <= $signed(i_measured);
            r_p    <= $signed(i_predicted);
        end
        if (r_state == ST_FF && mul_done) begin
            r_ff    <= prod[63:16];
            r_pterm <= '0;
        end
        if (r_state == ST_SQ && mul_done) r_sq <= sat32(54'(sh16));
        if (r_state == ST_PT && mul_done) r_pterm <= prod[63:16];
        if (r_state == ST_ERR) r_err <= err_c;
        if (r_state == ST_DIF) r_d <= d_c;
        if (r_state == ST_P && mul_done) r_sum <= 54'(sh16) + 54'(r_acc) + 54'(r_ff);
        if (r_state == ST_D && mul_done) r_sum <= r_sum + 54'(sh16);
        if (r_state == ST_CLAMP && (!r_out_valid || !i_out_stall)) r_drive <= out_c;
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    // The multiplier only finishes inside a multiply step
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_FF || r_state == ST_SQ || r_state == ST_PT ||
                      r_state == ST_INT || r_state == ST_DER || r_state == ST_P ||
                      r_state == ST_D))
        else $error("multiplier finished outside a multiply step");

    // A running transaction starts the feedforward product next cycle
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && run) |=> (r_state == ST_FF && r_start))
        else $error("accepted transaction did not start the sequence");

    // A new result only comes from the clamp step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_CLAMP))
        else $error("result raised outside the clamp step");

endmodule

// ----- tb/tb_pid_position_controller.sv -----
// ----------------------------------------------------------------------------
// tb_pid_position_controller
// Drives random and directed samples through the PID step under changing
// register settings and checks every drive value against a local predictor.
// ----------------------------------------------------------------------------
class pid_scoreboard;
    logic [5:0]         mode;
    logic signed [31:0] kp, ki, kd, kff, coef;
    logic [30:0]        ibound, olimit;
    longint             acc, last_err, filt_d, last_tgt;
    logic signed [31:0] drive_q[$];
    int                 errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        mode = 0; kp = 0; ki = 0; kd = 0; kff = 0; coef = 0;
        ibound = 31'h7FFFFFFF; olimit = 31'h7FFFFFFF;
        acc = 0; last_err = 0; filt_d = 0; last_tgt = 0;
    endfunction

    function void write_reg(pid_pkg::t_cfg_idx idx, logic [31:0] v);
        case (idx)
            pid_pkg::CFG_MODE:    mode = v[5:0];
            pid_pkg::CFG_GAIN_P:  kp = v;
            pid_pkg::CFG_GAIN_I:  ki = v;
            pid_pkg::CFG_GAIN_D:  kd = v;
            pid_pkg::CFG_GAIN_FF: kff = v;
            pid_pkg::CFG_DCOEF:   coef = v;
            pid_pkg::CFG_IBOUND:  ibound = v[30:0];
            pid_pkg::CFG_OLIMIT:  olimit = v[30:0];
            default: ;
        endcase
    endfunction

    static function longint clip(longint x, longint lo, longint hi);
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    // Arithmetic right shift of a signed 64-bit value floors toward minus infinity
    static function longint fsh(longint x, int n);
        return x >>> n;
    endfunction

    function void note_sample(logic signed [31:0] sp, logic signed [31:0] ms,
                              logic signed [31:0] pr);
        longint tgt, meas, p, mag, sq, pterm, err, ff, stp, d, dv, outv, lim, ib;
        longint i32max, i32min, accmax, accmin;
        i32max = 64'sd2147483647; i32min = -64'sd2147483648;
        accmax = 64'sd140737488355327; accmin = -accmax - 1;
        if (!mode[5]) return;
        lim = longint'(pid_pkg::SETPOINT_MAX);
        tgt = clip(longint'(sp), -lim, lim);
        meas = longint'(ms);
        p = longint'(pr);
        ff = fsh(longint'(kff) * tgt, 16);
        pterm = 0;
        if (mode[4] && p != 0) begin
            mag = p < 0 ? -p : p;
            sq = clip(fsh(p * mag, 16), i32min, i32max);
            pterm = fsh(longint'(pid_pkg::PREDICT_GAIN) * sq, 16);
        end
        err = tgt - meas - pterm;
        if (err < longint'(pid_pkg::DEAD_ZONE) && err > -longint'(pid_pkg::DEAD_ZONE))
            err = 0;
        err = clip(err, -longint'(pid_pkg::ERROR_LIMIT), longint'(pid_pkg::ERROR_LIMIT));
        ib = longint'(ibound);
        if (ki == 0) begin
            acc = 0;
        end else begin
            stp = fsh(longint'(ki) * err, 16);
            case (mode[1:0])
                pid_pkg::IMODE_SEP: begin
                    if (err > ib || err < -ib) stp = 0;
                    acc = clip(acc + stp, accmin, accmax);
                end
                pid_pkg::IMODE_AWU: begin
                    if (acc > ib) acc = ib;
                    else if (acc < -ib) acc = -ib;
                    else acc = clip(acc + stp, accmin, accmax);
                end
                pid_pkg::IMODE_TRAP: begin
                    stp = fsh(longint'(ki) * (err + last_err), 17);
                    acc = clip(acc + stp, accmin, accmax);
                end
                default: acc = clip(acc + stp, accmin, accmax);
            endcase
        end
        d = clip(err - last_err, i32min, i32max);
        if (mode[3:2] == pid_pkg::DMODE_LPF)
            dv = filt_d + fsh(longint'(coef) * (d - filt_d), 16);
        else if (mode[3:2] == pid_pkg::DMODE_SPW)
            dv = d - fsh(longint'(coef) * (tgt - last_tgt), 16);
        else
            dv = d;
        filt_d = clip(dv, i32min, i32max);
        outv = fsh(longint'(kp) * err, 16) + acc + fsh(longint'(kd) * filt_d, 16) + ff;
        outv = clip(outv, -longint'(olimit), longint'(olimit));
        last_tgt = tgt;
        last_err = err;
        drive_q.push_back(outv[31:0]);
    endfunction

    function void check_drive(logic [31:0] got);
        logic [31:0] want;
        if (drive_q.size() == 0) begin
            $display("%0t: unexpected drive expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = drive_q.pop_front();
        if (got !== want) begin
            $display("%0t: drive mismatch expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_pid_position_controller;
    import pid_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall;
    logic [31:0] i_setpoint, i_measured, i_predicted;
    logic        o_out_valid, i_out_stall;
    logic [31:0] o_drive;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;

    pid_scoreboard sb;
    bit            quiet;      // no idling in the final stretch
    int            idle_cycles;

    pid_position_controller dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, check every accepted transaction
    initial begin
        int burst;
        i_out_stall = 0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_drive(o_drive);
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
                i_out_stall = 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                i_out_stall = 1;
            end else begin
                i_out_stall = 0;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic send_sample(logic [31:0] sp, logic [31:0] ms, logic [31:0] pr);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_setpoint = sp;
        i_measured = ms;
        i_predicted = pr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(sp, ms, pr);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    // Drain results, then let the sequencer settle before a register write
    task automatic drain();
        while (sb.drive_q.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255) << 16;
            3: return -($urandom_range(0, 255) << 16);
            4: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_gain();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom;
            default: return $urandom_range(0, 131072) - 65536;
        endcase
    endfunction

    task automatic random_setting(bit extreme);
        write_reg(CFG_MODE, {26'd0, 1'b1, 5'($urandom)});
        write_reg(CFG_GAIN_P, extreme ? 32'h80000000 : rnd_gain());
        write_reg(CFG_GAIN_I, extreme ? 32'h7FFFFFFF : rnd_gain());
        write_reg(CFG_GAIN_D, extreme ? 32'h7FFFFFFF : rnd_gain());
        write_reg(CFG_GAIN_FF, extreme ? 32'h80000000 : rnd_gain());
        write_reg(CFG_DCOEF, extreme ? 32'h80000000 : rnd_gain());
        write_reg(CFG_IBOUND, extreme ? 32'h0 :
                  ($urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : 32'($urandom_range(0, 1 << 24))));
        write_reg(CFG_OLIMIT, extreme ? 32'h7FFFFFFF :
                  ($urandom_range(0, 2) == 0 ? 32'h7FFFFFFF : 32'($urandom_range(0, 1 << 26))));
    endtask

    initial begin
        sb = new();
        quiet = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_setpoint = 0; i_measured = 0; i_predicted = 0;
        i_cfg_we = 0; i_cfg_index = CFG_MODE; i_cfg_wdata = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Run off: samples are dropped
        send_sample(32'h00010000, 0, 0);
        send_sample(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        drain();

        // Directed: each integral and derivative mode, prediction on odd modes, extremes
        write_reg(CFG_GAIN_P, 32'h00010000);
        write_reg(CFG_GAIN_I, 32'h00008000);
        write_reg(CFG_GAIN_D, 32'h00004000);
        write_reg(CFG_GAIN_FF, 32'h00002000);
        write_reg(CFG_DCOEF, 32'h00008000);
        write_reg(CFG_IBOUND, 32'h00030000);
        write_reg(CFG_OLIMIT, 32'h7FFFFFFF);
        for (int m = 0; m < 16; m++) begin
            write_reg(CFG_MODE, {26'd0, 1'b1, m[0], m[3:0]});
            send_sample(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
            send_sample(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
            drain();
        end
        // Zero integral gain clears the accumulator
        write_reg(CFG_GAIN_I, 0);
        send_sample(32'h00050000, 0, 0);
        drain();
        write_reg(CFG_OLIMIT, 0);
        send_sample(32'h00050000, 32'hFFFF0000, 0);
        drain();
        random_setting(1);
        send_sample(32'h7FFFFFFF, 32'h80000000, 0);
        send_sample(32'h80000000, 32'h7FFFFFFF, 0);
        drain();

        // Random phases
        for (int ph = 0; ph < 38; ph++) begin
            random_setting(ph == 20);
            if (ph == 35) quiet = 1;
            for (int k = 0; k < 50; k++) begin
                if (ph == 10 && k == 25)
                    while (sb.drive_q.size() != 0) @(negedge i_clk);
                send_sample(rnd_val(), rnd_val(), rnd_val());
            end
            drain();
        end

        if (sb.errors == 0 && sb.drive_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
